// ----- hw/rtl/linear_probe_hash_table_macros.svh -----
// Assertion macros shared by the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside of reset.
`define LPHT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside of reset.
`define LPHT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LPHT_ASSERT(label, clk, rst_n, prop, msg)
`define LPHT_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- hw/rtl/lpht_pkg.sv -----
// Types and codes shared by the hash table controller, datapath and top level.
package lpht_pkg;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } lpht_op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_ZERO = 2'd3
  } lpht_status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_MOD_GO,
    S_MOD,
    S_LOOK_RD,
    S_LOOK_CHK,
    S_PLACE_RD,
    S_PLACE_CHK,
    S_COPY_RD,
    S_COPY_WR,
    S_SCAN_RD,
    S_SCAN_CHK
  } lpht_state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] value;
  } lpht_req_t;

  typedef struct packed {
    lpht_status_e status;
    logic [31:0]  found_value;
    logic [8:0]   entry_count;
  } lpht_rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
  } lpht_slot_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic         accept;
    logic         idx_clr;
    logic         idx_inc;
    logic         idx_home;
    logic         clr_wr;
    logic         copy_wr;
    logic         place_wr;
    logic         probe_clr;
    logic         probe_inc;
    logic         sweep_clr;
    logic         sweep_inc;
    logic         cur_from_scr;
    logic         mod_start;
    logic         mark_drop;
    logic         count_clr;
    logic         emit;
    lpht_status_e emit_status;
    logic         emit_found;
    logic         emit_remove;
  } lpht_ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic       key_zero;
    logic [1:0] cmd;
    logic       full;
    logic       mod_done;
    logic       idx_last;
    logic       sweep_last;
    logic       probe_first;
    logic       probe_last;
    logic       slot_empty;
    logic       slot_match;
    logic       scan_empty;
    logic       scan_match;
  } lpht_sts_t;

endpackage

// ----- hw/rtl/lpht_mod.sv -----
// Remainder unit: key modulo SLOTS by reciprocal multiplication.
`include "linear_probe_hash_table_macros.svh"
module lpht_mod #(
  parameter int SLOTS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                dividend_i,
  output logic                       done_o,
  output logic [$clog2(SLOTS)-1:0]   rem_o
);

  localparam int IW = $clog2(SLOTS);
  // floor(2^32 / SLOTS): the quotient estimate is low by at most one.
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(SLOTS));
  localparam logic [31:0] DIV   = 32'(SLOTS);

  logic          stage1_q, stage1_d;
  logic          stage2_q, stage2_d;
  logic          done_q, done_d;
  logic [31:0]   num_q;
  logic [63:0]   prod_q, prod_d;
  logic [31:0]   part_q, part_d;
  logic [31:0]   fix;
  logic [IW-1:0] rem_q, rem_d;

  always_comb begin
    stage1_d = start_i;
    stage2_d = stage1_q;
    done_d   = start_i ? 1'b0 : (done_q || stage2_q);
    prod_d   = 64'(dividend_i) * 64'(RECIP);
    // partial remainder is below 2*SLOTS; one compare and subtract finishes it
    part_d   = num_q - prod_q[63:32] * DIV;
    fix      = (part_q >= DIV) ? part_q - DIV : part_q;
    rem_d    = fix[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage1_q <= 1'b0;
      stage2_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      stage1_q <= stage1_d;
      stage2_q <= stage2_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= dividend_i;
      prod_q <= prod_d;
    end
    if (stage1_q) begin
      part_q <= part_d;
    end
    if (stage2_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  `LPHT_ASSERT(a_rem_in_range, clk_i, rst_ni, done_q |-> (32'(rem_q) < DIV), "remainder out of range")
  `LPHT_ASSERT_NEVER(a_no_restart, clk_i, rst_ni, start_i && (stage1_q || stage2_q), "restart while dividing")

endmodule

// ----- hw/rtl/lpht_dp.sv -----
// Hash table datapath: slot memory, scratch memory, indexes, count and result register.
`include "linear_probe_hash_table_macros.svh"
module lpht_dp #(
  parameter int SLOTS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpht_pkg::lpht_req_t req_i,
  input  lpht_pkg::lpht_ctl_t cmd_i,
  output lpht_pkg::lpht_sts_t sts_o,
  output logic                done_o,
  output lpht_pkg::lpht_rsp_t rsp_o
);
  import lpht_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  lpht_req_t   req_q;
  logic [31:0] cur_key_q, cur_key_d;
  logic [31:0] cur_val_q, cur_val_d;
  logic [IW-1:0] idx_q, idx_d, idx_next;
  logic [IW-1:0] probe_q, probe_d;
  logic [IW-1:0] sweep_q, sweep_d;
  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic          done_q;
  lpht_rsp_t     rsp_q, rsp_d;

  lpht_slot_t main_mem [SLOTS];
  lpht_slot_t scr_mem  [SLOTS];
  lpht_slot_t main_rd_q;
  lpht_slot_t scr_rd_q;

  logic          mod_done;
  logic [IW-1:0] mod_rem;

  lpht_mod #(.SLOTS(SLOTS)) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mod_start),
    .dividend_i(cur_key_q),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  assign idx_next = (idx_q == IW'(SLOTS - 1)) ? '0 : idx_q + IW'(1);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_home) begin
      idx_d = mod_rem;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_next;
    end

    probe_d = probe_q;
    if (cmd_i.probe_clr) begin
      probe_d = '0;
    end else if (cmd_i.probe_inc) begin
      probe_d = probe_q + IW'(1);
    end

    sweep_d = sweep_q;
    if (cmd_i.sweep_clr) begin
      sweep_d = '0;
    end else if (cmd_i.sweep_inc) begin
      sweep_d = sweep_q + IW'(1);
    end

    count_d = count_q;
    if (cmd_i.count_clr) begin
      count_d = '0;
    end else if (cmd_i.place_wr) begin
      count_d = count_q + CW'(1);
    end

    dropped_d = dropped_q;
    if (cmd_i.sweep_clr) begin
      dropped_d = 1'b0;
    end else if (cmd_i.mark_drop) begin
      dropped_d = 1'b1;
    end

    cur_key_d = cur_key_q;
    cur_val_d = cur_val_q;
    if (cmd_i.accept) begin
      cur_key_d = req_i.key;
      cur_val_d = req_i.value;
    end else if (cmd_i.cur_from_scr) begin
      cur_key_d = scr_rd_q.key;
      cur_val_d = scr_rd_q.value;
    end

    rsp_d.status      = cmd_i.emit_status;
    if (cmd_i.emit_remove) begin
      rsp_d.status = (dropped_q || cmd_i.mark_drop) ? ST_OK : ST_MISS;
    end
    rsp_d.found_value = cmd_i.emit_found ? main_rd_q.value : '0;
    rsp_d.entry_count = 9'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      probe_q   <= '0;
      sweep_q   <= '0;
      count_q   <= '0;
      dropped_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      probe_q   <= probe_d;
      sweep_q   <= sweep_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      done_q    <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
    end
    cur_key_q <= cur_key_d;
    cur_val_q <= cur_val_d;
    if (cmd_i.emit) begin
      rsp_q <= rsp_d;
    end
  end

  // Slot memory: one write and one registered read per cycle, both at idx_q.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr || cmd_i.copy_wr) begin
      main_mem[idx_q] <= '0;
    end else if (cmd_i.place_wr) begin
      main_mem[idx_q] <= '{key: cur_key_q, value: cur_val_q};
    end
    main_rd_q <= main_mem[idx_q];
  end

  // Scratch memory: filled by the copy sweep, read by the rebuild sweep.
  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_wr) begin
      scr_mem[idx_q] <= main_rd_q;
    end
    scr_rd_q <= scr_mem[sweep_q];
  end

  always_comb begin
    sts_o.key_zero    = (req_q.key == '0);
    sts_o.cmd         = req_q.cmd;
    sts_o.full        = (count_q >= CW'(SLOTS));
    sts_o.mod_done    = mod_done;
    sts_o.idx_last    = (idx_q == IW'(SLOTS - 1));
    sts_o.sweep_last  = (sweep_q == IW'(SLOTS - 1));
    sts_o.probe_first = (probe_q == '0);
    sts_o.probe_last  = (probe_q == IW'(SLOTS - 1));
    sts_o.slot_empty  = (main_rd_q.key == '0);
    sts_o.slot_match  = (main_rd_q.key == cur_key_q);
    sts_o.scan_empty  = (scr_rd_q.key == '0);
    sts_o.scan_match  = (scr_rd_q.key == req_q.key);
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `LPHT_ASSERT(a_place_into_empty, clk_i, rst_ni, cmd_i.place_wr |-> (main_rd_q.key == '0), "place over occupied slot")
  `LPHT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(SLOTS), "entry count above slot count")

endmodule

// ----- hw/rtl/lpht_ctrl.sv -----
// Hash table controller: sequences clear, lookup, insert and remove/rebuild.
module lpht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  lpht_pkg::lpht_sts_t sts_i,
  output logic                busy_o,
  output lpht_pkg::lpht_ctl_t cmd_o
);
  import lpht_pkg::*;

  lpht_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.emit_status = ST_MISS;
    case (state_q)
      S_INIT: begin
        // sweep the slot memory to empty after reset
        cmd_o.clr_wr  = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.key_zero) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_ZERO;
          state_d           = S_IDLE;
        end else begin
          case (sts_i.cmd)
            CMD_LOOKUP: begin
              cmd_o.mod_start = 1'b1;
              state_d         = S_MOD;
            end
            CMD_INSERT: begin
              if (sts_i.full) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = ST_FULL;
                state_d           = S_IDLE;
              end else begin
                cmd_o.mod_start = 1'b1;
                state_d         = S_MOD;
              end
            end
            CMD_REMOVE: begin
              cmd_o.count_clr = 1'b1;
              cmd_o.sweep_clr = 1'b1;
              cmd_o.idx_clr   = 1'b1;
              state_d         = S_COPY_RD;
            end
            default: begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = ST_MISS;
              state_d           = S_IDLE;
            end
          endcase
        end
      end
      S_MOD_GO: begin
        cmd_o.mod_start = 1'b1;
        state_d         = S_MOD;
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          cmd_o.idx_home  = 1'b1;
          cmd_o.probe_clr = 1'b1;
          state_d = (sts_i.cmd == CMD_LOOKUP) ? S_LOOK_RD : S_PLACE_RD;
        end
      end
      S_LOOK_RD: begin
        state_d = S_LOOK_CHK;
      end
      S_LOOK_CHK: begin
        if (sts_i.slot_match) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_OK;
          cmd_o.emit_found  = 1'b1;
          state_d           = S_IDLE;
        end else if ((sts_i.probe_first && sts_i.slot_empty) || sts_i.probe_last) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_MISS;
          state_d           = S_IDLE;
        end else begin
          cmd_o.probe_inc = 1'b1;
          cmd_o.idx_inc   = 1'b1;
          state_d         = S_LOOK_RD;
        end
      end
      S_PLACE_RD: begin
        state_d = S_PLACE_CHK;
      end
      S_PLACE_CHK: begin
        if (sts_i.slot_empty) begin
          cmd_o.place_wr = 1'b1;
          if (sts_i.cmd == CMD_INSERT) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ST_OK;
            state_d           = S_IDLE;
          end else if (sts_i.sweep_last) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_remove = 1'b1;
            state_d           = S_IDLE;
          end else begin
            cmd_o.sweep_inc = 1'b1;
            state_d         = S_SCAN_RD;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_PLACE_RD;
        end
      end
      S_COPY_RD: begin
        state_d = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd_o.copy_wr = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d = sts_i.idx_last ? S_SCAN_RD : S_COPY_RD;
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts_i.scan_empty || sts_i.scan_match) begin
          cmd_o.mark_drop = !sts_i.scan_empty;
          if (sts_i.sweep_last) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_remove = 1'b1;
            state_d           = S_IDLE;
          end else begin
            cmd_o.sweep_inc = 1'b1;
            state_d         = S_SCAN_RD;
          end
        end else begin
          cmd_o.cur_from_scr = 1'b1;
          state_d            = S_MOD_GO;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- hw/rtl/linear_probe_hash_table.sv -----
// Top level of the open-addressing hash table with linear probing.
//
// A request (lookup, insert or remove of a 32-bit key) is taken at a rising
// edge where start is high and busy is low; its single response goes to
// rsp_o, flagged by done_o for exactly one cycle, and cannot be held off.
// The length of each request is set by the walk of the single-port slot
// memory: the home slot (key mod SLOTS) comes from a remainder unit that
// multiplies by the reciprocal of SLOTS, and every probe is a registered
// read, then a compare. The next request can be taken at the edge that ends
// the response cycle; a key of zero, a full table or an unused command are
// answered from the dispatch state with no slot walk. Remove copies the
// table into scratch memory while clearing it, scans the copy and reinserts
// each survivor. After reset the block sweeps the slot memory empty and
// holds busy high.
`include "linear_probe_hash_table_macros.svh"
module linear_probe_hash_table #(
  parameter int SLOTS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lpht_pkg::lpht_req_t req_i,
  output logic                done_o,
  output lpht_pkg::lpht_rsp_t rsp_o
);
  import lpht_pkg::*;

  // Command and status between controller and datapath.
  lpht_ctl_t ctl;
  lpht_sts_t sts;

  // Controller: owns busy and decides every step of a request.
  lpht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .busy_o (busy),
    .cmd_o  (ctl)
  );

  // Datapath: memories, probe index, entry count and the response register.
  lpht_dp #(.SLOTS(SLOTS)) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (ctl),
    .sts_o (sts),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  // A taken request must raise busy on the next cycle.
  `LPHT_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "busy not raised after request")
  // A response always closes a busy period.
  `LPHT_ASSERT(a_done_after_busy, clk_i, rst_ni, done_o |-> $past(busy), "response without request")

endmodule
